>>> design/qvr_pkg.sv
// Shared widths, codes and types for the quaternion vector rotation block.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;
	localparam int CW   = 16;           // component width
	localparam int FB   = 14;           // fraction bits
	localparam int SW   = 2 * CW;       // sum of squares
	localparam int RW   = CW + FB;      // root of s * 2^(2F)
	localparam int REMW = RW + 2;       // root remainder
	localparam int DW   = RW + 1;       // divisor 2 * len
	localparam int QB   = FB + 1;       // quotient bits
	localparam int NW   = CW + 2 * FB + 2; // rounding numerator
	localparam int UW   = FB + 2;       // signed unit component
	localparam int PW   = UW + CW;      // first products
	localparam int TW   = PW + 2;       // v * conj(q) parts
	localparam int P2W  = CW + TW;      // second products
	localparam int RESW = P2W + 2;      // q * t parts
	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_ROT_X,
		REG_ROT_Y,
		REG_ROT_Z,
		REG_ROT_W
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] w;
	} quat_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} meta_t;
endpackage
`default_nettype wire

>>> design/quaternion_vector_rotation.sv
// Top level of the quaternion vector rotation pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Rotates each input vector by the quaternion in rot_x/y/z/w (signed Q1.14,
// reset to identity). The vector is scaled to unit length, then q * v * conj(q)
// is formed and its x, y, z parts are rounded and saturated to 16 bits. An
// all-zero vector gives zeros with zero_input set. One beat is taken per
// clock while no result waits under out_stall. A squared-length register feeds
// the 30-stage square root (one root bit per stage), then the 15-stage dividers
// (one quotient bit per stage, three lanes side by side, one per component)
// and the merge stages. The whole pipeline advances together and holds only
// when a result sits unclaimed in the output register under out_stall. Write
// the rotation registers only while no beat is in flight.
module quaternion_vector_rotation (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wen,
	input  wire logic [qvr_pkg::CFG_IW-1:0]           cfg_idx,
	input  wire logic [qvr_pkg::CW-1:0]               cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [qvr_pkg::CW-1:0]        vec_x,
	input  wire logic signed [qvr_pkg::CW-1:0]        vec_y,
	input  wire logic signed [qvr_pkg::CW-1:0]        vec_z,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [qvr_pkg::CW-1:0]             out_x,
	output logic signed [qvr_pkg::CW-1:0]             out_y,
	output logic signed [qvr_pkg::CW-1:0]             out_z,
	output logic                                      zero_input
);
	localparam int CW = qvr_pkg::CW;
	localparam int SW = qvr_pkg::SW;
	localparam int QB = qvr_pkg::QB;
	localparam int UW = qvr_pkg::UW;
	localparam int FB = qvr_pkg::FB;
	localparam logic signed [UW-1:0] UMAX = UW'(1 << FB);

	qvr_pkg::quat_t rot_q;
	logic           en;

	// rotation registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.x <= '0;
			rot_q.y <= '0;
			rot_q.z <= '0;
			rot_q.w <= CW'(1 << FB);
		end else if (cfg_wen) begin
			unique case (qvr_pkg::cfg_reg_t'(cfg_idx))
				qvr_pkg::REG_ROT_X: rot_q.x <= cfg_data;
				qvr_pkg::REG_ROT_Y: rot_q.y <= cfg_data;
				qvr_pkg::REG_ROT_Z: rot_q.z <= cfg_data;
				qvr_pkg::REG_ROT_W: rot_q.w <= cfg_data;
			endcase
		end
	end

	// global advance: hold only when the output beat is waiting
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: squared length
	qvr_pkg::meta_t meta_s1;
	qvr_pkg::vec_t  vec_s1;
	logic [SW-1:0]  s_s1;
	logic [SW-1:0]  sq_x, sq_y, sq_z;

	assign sq_x = SW'(vec_x * vec_x);
	assign sq_y = SW'(vec_y * vec_y);
	assign sq_z = SW'(vec_z * vec_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1.valid <= in_valid;
			meta_s1.zero  <= (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= '{x: vec_x, y: vec_y, z: vec_z};
			s_s1   <= sq_x + sq_y + sq_z;
		end
	end

	// length
	qvr_pkg::meta_t          sq_meta;
	qvr_pkg::vec_t           sq_vec;
	logic [qvr_pkg::RW-1:0]  root;

	qvr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_meta  (meta_s1),
		.in_vec   (vec_s1),
		.in_s     (s_s1),
		.out_meta (sq_meta),
		.out_vec  (sq_vec),
		.out_root (root)
	);

	// three divider lanes, control follows alongside
	qvr_pkg::meta_t          dmeta_s [QB+1];
	logic signed [UW-1:0]    ux, uy, uz;

	assign dmeta_s[0] = sq_meta;
	for (genvar k = 0; k < QB; k++) begin : g_dmeta
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dmeta_s[k+1] <= '0;
			end else if (en) begin
				dmeta_s[k+1] <= dmeta_s[k];
			end
		end
	end

	qvr_div_lane u_lane_x (.clk(clk), .en(en), .comp(sq_vec.x), .len(root), .unit(ux));
	qvr_div_lane u_lane_y (.clk(clk), .en(en), .comp(sq_vec.y), .len(root), .unit(uy));
	qvr_div_lane u_lane_z (.clk(clk), .en(en), .comp(sq_vec.z), .len(root), .unit(uz));

	// rotation and output register
	qvr_pkg::meta_t out_meta;

	qvr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_meta  (dmeta_s[QB]),
		.ux       (ux),
		.uy       (uy),
		.uz       (uz),
		.rot      (rot_q),
		.out_meta (out_meta),
		.rx       (out_x),
		.ry       (out_y),
		.rz       (out_z)
	);

	assign out_valid  = out_meta.valid;
	assign zero_input = out_meta.zero;

	unit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dmeta_s[QB].valid && !dmeta_s[QB].zero |->
			ux <= UMAX && ux >= -UMAX && uy <= UMAX && uy >= -UMAX &&
			uz <= UMAX && uz >= -UMAX)
		else $error("unit component beyond one");

	zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_input |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("zero vector gave nonzero result");

	zero_flag_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		sq_meta.valid && sq_meta.zero |->
			sq_vec.x == '0 && sq_vec.y == '0 && sq_vec.z == '0)
		else $error("zero flag out of step with vector");
endmodule
`default_nettype wire

>>> design/qvr_sqrt.sv
// Bit-per-stage integer square root of s * 2^(2F), carrying the vector along.
`timescale 1ns / 1ps
`default_nettype none
module qvr_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire qvr_pkg::meta_t           in_meta,
	input  wire qvr_pkg::vec_t            in_vec,
	input  wire logic [qvr_pkg::SW-1:0]   in_s,
	output qvr_pkg::meta_t                out_meta,
	output qvr_pkg::vec_t                 out_vec,
	output logic [qvr_pkg::RW-1:0]        out_root
);
	localparam int RW   = qvr_pkg::RW;
	localparam int REMW = qvr_pkg::REMW;
	localparam int FB   = qvr_pkg::FB;

	qvr_pkg::meta_t          meta_s [RW+1];
	qvr_pkg::vec_t           vec_s  [RW+1];
	logic [qvr_pkg::SW-1:0]  rad_s  [RW+1];
	logic [REMW-1:0]         rem_s  [RW+1];
	logic [RW-1:0]           root_s [RW+1];

	assign meta_s[0] = in_meta;
	assign vec_s[0]  = in_vec;
	assign rad_s[0]  = in_s;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int P = RW - 1 - k;   // radicand bit pair handled here
		logic [1:0]      pair;
		logic [REMW+1:0] cur;
		logic [REMW+1:0] trial;
		logic            take;

		if (P >= FB) begin : g_data
			assign pair = rad_s[k][2*(P-FB)+1 -: 2];
		end else begin : g_pad
			assign pair = 2'b00;     // low pairs of s * 2^(2F) are zero
		end

		assign cur   = {rem_s[k], pair};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_s[k+1] <= '0;
			end else if (en) begin
				meta_s[k+1] <= meta_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1]  <= vec_s[k];
				rad_s[k+1]  <= rad_s[k];
				rem_s[k+1]  <= take ? REMW'(cur - trial) : REMW'(cur);
				root_s[k+1] <= {root_s[k][RW-2:0], take};
			end
		end
	end

	assign out_meta = meta_s[RW];
	assign out_vec  = vec_s[RW];
	assign out_root = root_s[RW];

	sqrt_nonzero_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_meta.valid && !out_meta.zero |-> out_root != '0)
		else $error("nonzero vector produced a zero length");
endmodule
`default_nettype wire

>>> design/qvr_div_lane.sv
// One divider lane: unit component = c * 2^(2F) / len, rounded half away from zero.
`timescale 1ns / 1ps
`default_nettype none
module qvr_div_lane (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [qvr_pkg::CW-1:0]  comp,
	input  wire logic [qvr_pkg::RW-1:0]         len,
	output logic signed [qvr_pkg::UW-1:0]       unit
);
	localparam int CW = qvr_pkg::CW;
	localparam int FB = qvr_pkg::FB;
	localparam int DW = qvr_pkg::DW;
	localparam int QB = qvr_pkg::QB;
	localparam int NW = qvr_pkg::NW;

	logic [CW-1:0] mag;
	logic [NW-1:0] num;

	logic [DW-1:0] rem_s [QB+1];
	logic [QB-1:0] nlo_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [DW-1:0] div_s [QB+1];
	logic          neg_s [QB+1];

	assign mag = comp[CW-1] ? CW'(-comp) : CW'(comp);
	// (2|c| * 2^(2F) + len) / (2 len) rounds to nearest, ties away
	assign num = {mag, {(2*FB+1){1'b0}}} + NW'(len);

	assign rem_s[0] = num[NW-1:QB];
	assign nlo_s[0] = num[QB-1:0];
	assign quo_s[0] = '0;
	assign div_s[0] = {len, 1'b0};
	assign neg_s[0] = comp[CW-1];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DW:0] trial;
		logic        take;

		assign trial = {rem_s[k], nlo_s[k][QB-1]};
		assign take  = (trial >= {1'b0, div_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? DW'(trial - {1'b0, div_s[k]}) : DW'(trial);
				nlo_s[k+1] <= {nlo_s[k][QB-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QB-2:0], take};
				div_s[k+1] <= div_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign unit = neg_s[QB] ? -$signed({1'b0, quo_s[QB]}) : $signed({1'b0, quo_s[QB]});
endmodule
`default_nettype wire

>>> design/qvr_merge.sv
// Merge stage: q * (v * conj(q)) from the lane results, then round and saturate.
`timescale 1ns / 1ps
`default_nettype none
module qvr_merge (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire qvr_pkg::meta_t                 in_meta,
	input  wire logic signed [qvr_pkg::UW-1:0]  ux,
	input  wire logic signed [qvr_pkg::UW-1:0]  uy,
	input  wire logic signed [qvr_pkg::UW-1:0]  uz,
	input  wire qvr_pkg::quat_t                 rot,
	output qvr_pkg::meta_t                      out_meta,
	output logic signed [qvr_pkg::CW-1:0]       rx,
	output logic signed [qvr_pkg::CW-1:0]       ry,
	output logic signed [qvr_pkg::CW-1:0]       rz
);
	localparam int CW   = qvr_pkg::CW;
	localparam int FB   = qvr_pkg::FB;
	localparam int PW   = qvr_pkg::PW;
	localparam int TW   = qvr_pkg::TW;
	localparam int P2W  = qvr_pkg::P2W;
	localparam int RESW = qvr_pkg::RESW;
	localparam logic signed [RESW-1:0] HI   = RESW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [RESW-1:0] LO   = -HI - RESW'(1);
	localparam logic signed [RESW-1:0] HALF = RESW'(64'sd1 <<< (2 * FB - 1));

	function automatic logic signed [CW-1:0] rnd_sat(input logic signed [RESW-1:0] v);
		logic signed [RESW-1:0] a;
		a = (v >>> FB) + HALF;
		a = a >>> (2 * FB);
		if (a > HI) begin
			return HI[CW-1:0];
		end else if (a < LO) begin
			return LO[CW-1:0];
		end
		return a[CW-1:0];
	endfunction

	qvr_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4;

	// v * q part products
	logic signed [PW-1:0] p_s1 [12];
	// t = v * conj(q)
	logic signed [TW-1:0] t0_s2, t1_s2, t2_s2, t3_s2;
	// q * t part products
	logic signed [P2W-1:0] r_s3 [12];
	logic signed [CW-1:0] x_s4, y_s4, z_s4;
	logic signed [RESW-1:0] sx, sy, sz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
		end else if (en) begin
			meta_s1 <= in_meta;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
		end
	end

	assign sx = RESW'(r_s3[0]) + RESW'(r_s3[1]) + RESW'(r_s3[2]) - RESW'(r_s3[3]);
	assign sy = RESW'(r_s3[4]) + RESW'(r_s3[5]) + RESW'(r_s3[6]) - RESW'(r_s3[7]);
	assign sz = RESW'(r_s3[8]) + RESW'(r_s3[9]) + RESW'(r_s3[10]) - RESW'(r_s3[11]);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0]  <= ux * rot.w;
			p_s1[1]  <= uy * rot.z;
			p_s1[2]  <= uz * rot.y;
			p_s1[3]  <= uy * rot.w;
			p_s1[4]  <= uz * rot.x;
			p_s1[5]  <= ux * rot.z;
			p_s1[6]  <= uz * rot.w;
			p_s1[7]  <= ux * rot.y;
			p_s1[8]  <= uy * rot.x;
			p_s1[9]  <= ux * rot.x;
			p_s1[10] <= uy * rot.y;
			p_s1[11] <= uz * rot.z;

			t0_s2 <= TW'(p_s1[0]) - TW'(p_s1[1]) + TW'(p_s1[2]);
			t1_s2 <= TW'(p_s1[3]) - TW'(p_s1[4]) + TW'(p_s1[5]);
			t2_s2 <= TW'(p_s1[6]) - TW'(p_s1[7]) + TW'(p_s1[8]);
			t3_s2 <= TW'(p_s1[9]) + TW'(p_s1[10]) + TW'(p_s1[11]);

			r_s3[0]  <= rot.w * t0_s2;
			r_s3[1]  <= rot.x * t3_s2;
			r_s3[2]  <= rot.y * t2_s2;
			r_s3[3]  <= rot.z * t1_s2;
			r_s3[4]  <= rot.w * t1_s2;
			r_s3[5]  <= rot.y * t3_s2;
			r_s3[6]  <= rot.z * t0_s2;
			r_s3[7]  <= rot.x * t2_s2;
			r_s3[8]  <= rot.w * t2_s2;
			r_s3[9]  <= rot.z * t3_s2;
			r_s3[10] <= rot.x * t1_s2;
			r_s3[11] <= rot.y * t0_s2;

			x_s4 <= meta_s3.zero ? '0 : rnd_sat(sx);
			y_s4 <= meta_s3.zero ? '0 : rnd_sat(sy);
			z_s4 <= meta_s3.zero ? '0 : rnd_sat(sz);
		end
	end

	assign out_meta = meta_s4;
	assign rx = x_s4;
	assign ry = y_s4;
	assign rz = z_s4;
endmodule
`default_nettype wire
